FILE: rtl/core/hmq_pkg.sv
// Shared types and constants for the min-heap priority queue.
package hmq_pkg;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [31:0] prio;
    logic [31:0]        data;
  } hmq_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_RD,
    S_PUSH_CMP,
    S_POP_LAST,
    S_POP_RD,
    S_POP_CMP,
    S_TOP_RD,
    S_RESULT
  } hmq_state_t;

  typedef struct packed {
    logic idle;
    logic accept;
    logic pop_load;
    logic rd_parent;
    logic push_cmp;
    logic push_place;
    logic rd_children;
    logic pop_cmp;
    logic pop_place;
    logic out_load;
  } hmq_cmd_t;

  typedef struct packed {
    logic req_pop;
    logic full;
    logic empty;
    logic pos_zero;
    logic left_out;
    logic move_up;
    logic move_down;
    logic out_free;
  } hmq_sts_t;

endpackage

FILE: rtl/core/hmq_req_if.sv
// Request channel: one push or pop word.
interface hmq_req_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [31:0] item_priority;
  logic [31:0]        item_data;

  modport source (output valid, action, item_priority, item_data, input ready);
  modport sink (input valid, action, item_priority, item_data, output ready);
endinterface

FILE: rtl/core/hmq_rsp_if.sv
// Response channel: top of queue, count and status after each word.
interface hmq_rsp_if #(
  parameter int CntW = 7
);
  logic               valid;
  logic               ready;
  logic               top_valid;
  logic signed [31:0] top_priority;
  logic [31:0]        top_data;
  logic [CntW-1:0]    entry_total;
  logic [1:0]         status;

  modport source (output valid, top_valid, top_priority, top_data, entry_total, status,
                  input ready);
  modport sink (input valid, top_valid, top_priority, top_data, entry_total, status,
                output ready);
endinterface

FILE: rtl/core/hmq_ctrl.sv
// Sequencer for push sift-up, pop sift-down and result hand-off.
module hmq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  hmq_pkg::hmq_sts_t sts,
  output hmq_pkg::hmq_cmd_t cmd
);
  import hmq_pkg::*;

  hmq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          if (sts.req_pop) begin
            state_next = sts.empty ? S_TOP_RD : S_POP_LAST;
          end else begin
            state_next = sts.full ? S_TOP_RD : S_PUSH_RD;
          end
        end
      end
      S_PUSH_RD: begin
        if (sts.pos_zero) begin
          cmd.push_place = 1'b1;
          state_next     = S_TOP_RD;
        end else begin
          cmd.rd_parent = 1'b1;
          state_next    = S_PUSH_CMP;
        end
      end
      S_PUSH_CMP: begin
        cmd.push_cmp = 1'b1;
        state_next   = sts.move_up ? S_PUSH_RD : S_TOP_RD;
      end
      S_POP_LAST: begin
        cmd.pop_load = 1'b1;
        state_next   = S_POP_RD;
      end
      S_POP_RD: begin
        if (sts.left_out) begin
          cmd.pop_place = 1'b1;
          state_next    = S_TOP_RD;
        end else begin
          cmd.rd_children = 1'b1;
          state_next      = S_POP_CMP;
        end
      end
      S_POP_CMP: begin
        cmd.pop_cmp = 1'b1;
        state_next  = sts.move_down ? S_POP_RD : S_TOP_RD;
      end
      S_TOP_RD: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/hmq_dpath.sv
// Heap memory, count, walk position and output register.
module hmq_dpath #(
  parameter int CAPACITY = 64,
  parameter int AddrW    = 6,
  parameter int CntW     = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  hmq_pkg::hmq_cmd_t  cmd,
  output hmq_pkg::hmq_sts_t  sts,
  input  logic               action,
  input  logic signed [31:0] item_priority,
  input  logic [31:0]        item_data,
  hmq_rsp_if.source          rsp
);
  import hmq_pkg::*;

  localparam int CmpW = AddrW + 2;

  hmq_entry_t heap_mem [CAPACITY];
  hmq_entry_t rdata0, rdata1;
  logic [AddrW-1:0] raddr0, raddr1, waddr;
  hmq_entry_t wdata;
  logic we;

  logic [CntW-1:0]  cnt;
  logic [AddrW-1:0] pos;
  hmq_entry_t       mov;
  logic [1:0]       code;

  logic [AddrW-1:0] parent;
  logic [CmpW-1:0]  left, right, cnt_ext;
  logic             pick_right;
  hmq_entry_t       child_e;
  logic [AddrW-1:0] child_idx;

  logic               out_valid, out_top_valid;
  logic signed [31:0] out_prio;
  logic [31:0]        out_data;
  logic [CntW-1:0]    out_total;
  logic [1:0]         out_status;

  assign parent     = AddrW'((pos - 1'b1) >> 1);
  assign left       = {1'b0, pos, 1'b1};
  assign right      = left + CmpW'(1);
  assign cnt_ext    = CmpW'(cnt);
  assign pick_right = (right < cnt_ext) && (rdata1.prio < rdata0.prio);
  assign child_e    = pick_right ? rdata1 : rdata0;
  assign child_idx  = pick_right ? right[AddrW-1:0] : left[AddrW-1:0];

  always_comb begin
    sts.req_pop   = (action == OP_POP);
    sts.full      = (cnt == CntW'(CAPACITY));
    sts.empty     = (cnt == '0);
    sts.pos_zero  = (pos == '0);
    sts.left_out  = (left >= cnt_ext);
    sts.move_up   = (mov.prio < rdata0.prio);
    sts.move_down = (child_e.prio < mov.prio);
    sts.out_free  = !out_valid || rsp.ready;
  end

  // Read address: parent or children during the walk, last slot on accept, root otherwise.
  always_comb begin
    raddr0 = '0;
    raddr1 = '0;
    if (cmd.accept) begin
      raddr0 = AddrW'(cnt - 1'b1);
    end else if (cmd.rd_parent) begin
      raddr0 = parent;
    end else if (cmd.rd_children) begin
      raddr0 = left[AddrW-1:0];
      raddr1 = right[AddrW-1:0];
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = pos;
    wdata = mov;
    if (cmd.push_place || cmd.pop_place) begin
      we = 1'b1;
    end else if (cmd.push_cmp) begin
      we = 1'b1;
      if (sts.move_up) begin
        wdata = rdata0;
      end
    end else if (cmd.pop_cmp) begin
      we = 1'b1;
      if (sts.move_down) begin
        wdata = child_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      heap_mem[waddr] <= wdata;
    end
    rdata0 <= heap_mem[raddr0];
    rdata1 <= heap_mem[raddr1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.accept) begin
      if (action == OP_PUSH && !sts.full) begin
        cnt <= cnt + 1'b1;
      end else if (action == OP_POP && !sts.empty) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mov  <= '{prio: item_priority, data: item_data};
      pos  <= AddrW'(cnt);
      code <= STAT_DONE;
      if (action == OP_PUSH && sts.full) begin
        code <= STAT_FULL;
      end else if (action == OP_POP && sts.empty) begin
        code <= STAT_EMPTY;
      end
    end else if (cmd.pop_load) begin
      mov <= rdata0;
      pos <= '0;
    end else if (cmd.push_cmp && sts.move_up) begin
      pos <= parent;
    end else if (cmd.pop_cmp && sts.move_down) begin
      pos <= child_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_top_valid <= (cnt != '0);
      out_prio      <= (cnt != '0) ? rdata0.prio : 32'sd0;
      out_data      <= (cnt != '0) ? rdata0.data : 32'd0;
      out_total     <= cnt;
      out_status    <= code;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.top_valid    = out_top_valid;
  assign rsp.top_priority = out_prio;
  assign rsp.top_data     = out_data;
  assign rsp.entry_total  = out_total;
  assign rsp.status       = out_status;

endmodule

FILE: rtl/core/binary_min_heap_queue_core.sv
// Flow, accepted word to result register: a push sifts up from the new slot, a pop first loads
// the last entry and sifts down from the root; k levels moved, at most log2 CAPACITY.
// Each level takes a memory read step and then a compare-and-write step on the heap RAM.
// Dropped pushes and ignored pops skip the walk. One word is in flight at a time; the next
// is taken in the cycle after the result register loads, while that result still waits.
// Reset (synchronous, rst high) empties the queue; heap RAM contents are not cleared.
module binary_min_heap_queue_core #(
  parameter int CAPACITY = 64
) (
  input logic clk,
  input logic rst,
  hmq_req_if.sink   req,
  hmq_rsp_if.source rsp
);
  import hmq_pkg::*;

  localparam int AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CntW  = $clog2(CAPACITY + 1);

  hmq_cmd_t cmd;
  hmq_sts_t sts;

  hmq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  hmq_dpath #(
    .CAPACITY (CAPACITY),
    .AddrW    (AddrW),
    .CntW     (CntW)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .action        (req.action),
    .item_priority (req.item_priority),
    .item_data     (req.item_data),
    .rsp           (rsp)
  );

  assign req.ready = cmd.idle;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while previous word still in progress");

  a_empty_zeroed: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.top_valid) |->
      (rsp.entry_total == '0 && rsp.top_priority == 32'sd0 && rsp.top_data == 32'd0))
    else $error("empty result carries non-zero fields");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == STAT_FULL) |-> (rsp.entry_total == CntW'(CAPACITY)))
    else $error("push dropped while queue not full");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.entry_total <= CntW'(CAPACITY)))
    else $error("entry count beyond capacity");

endmodule

FILE: dv/tb_binary_min_heap_queue_core.sv
// Self-checking testbench for the min-heap priority queue core: directed and random push/pop words, shadow heap.
module tb_binary_min_heap_queue_core;
  import hmq_pkg::*;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = 7;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam longint TIMEOUT_CYCLES = 1_000_000;

  typedef struct packed {
    logic               action;
    logic signed [31:0] prio;
    logic [31:0]        data;
  } heap_word_t;

  typedef struct packed {
    logic               top_valid;
    logic signed [31:0] top_priority;
    logic [31:0]        top_data;
    logic [CNT_W-1:0]   entry_total;
    logic [1:0]         status;
  } queue_top_t;

  logic clk;
  logic rst;

  hmq_req_if                    req_ch ();
  hmq_rsp_if #(.CntW(CNT_W))    rsp_ch ();

  binary_min_heap_queue_core #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // shadow copy of the heap
  hmq_entry_t shadow_heap [CAPACITY];
  int         shadow_count = 0;

  heap_word_t pending_words [$];
  queue_top_t awaited_tops [$];

  int  words_queued   = 0;
  int  words_accepted = 0;
  int  err_count      = 0;
  bit  req_taken      = 1'b0;
  bit  calm           = 1'b0;
  int  holds_asked    = 0;
  int  holds_served   = 0;
  int  send_gap       = 0;
  int  hold_left      = 0;
  int  stall_left     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [31:0] pick_prio(int narrow_pct);
    int r;
    r = $urandom_range(0, 99);
    // narrow band forces ties between entries
    if (r < narrow_pct) return $signed($urandom_range(0, 15)) - 8;
    case ($urandom_range(0, 15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_data();
    case ($urandom_range(0, 19))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Apply one word to the shadow heap and queue the top it should report.
  function automatic void heap_update(logic act, logic signed [31:0] p, logic [31:0] d);
    queue_top_t want;
    hmq_entry_t moving;
    int pos, parent, left, right, child;
    want.status = STAT_DONE;
    if (act == OP_PUSH) begin
      if (shadow_count >= CAPACITY) begin
        want.status = STAT_FULL;
      end else begin
        pos = shadow_count;
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (!($signed(p) < $signed(shadow_heap[parent].prio))) break;
          shadow_heap[pos] = shadow_heap[parent];
          pos = parent;
        end
        shadow_heap[pos].prio = p;
        shadow_heap[pos].data = d;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        want.status = STAT_EMPTY;
      end else begin
        shadow_count--;
        shadow_heap[0] = shadow_heap[shadow_count];
        pos = 0;
        forever begin
          left  = 2 * pos + 1;
          right = left + 1;
          if (left >= shadow_count) break;
          child = left;
          if (right < shadow_count &&
              $signed(shadow_heap[right].prio) < $signed(shadow_heap[left].prio))
            child = right;
          if (!($signed(shadow_heap[child].prio) < $signed(shadow_heap[pos].prio))) break;
          moving             = shadow_heap[pos];
          shadow_heap[pos]   = shadow_heap[child];
          shadow_heap[child] = moving;
          pos = child;
        end
      end
    end
    if (shadow_count > 0) begin
      want.top_valid    = 1'b1;
      want.top_priority = shadow_heap[0].prio;
      want.top_data     = shadow_heap[0].data;
    end else begin
      want.top_valid    = 1'b0;
      want.top_priority = '0;
      want.top_data     = '0;
    end
    want.entry_total = shadow_count[CNT_W-1:0];
    awaited_tops.push_back(want);
  endfunction

  task automatic field_check(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want_v, got_v);
      err_count++;
    end
  endtask

  task automatic queue_word(logic act, logic signed [31:0] p, logic [31:0] d);
    heap_word_t w;
    w.action = act;
    w.prio   = p;
    w.data   = d;
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic queue_random(int n, int push_pct, int narrow_pct);
    logic act;
    for (int i = 0; i < n; i++) begin
      act = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
      queue_word(act, pick_prio(narrow_pct), pick_data());
    end
  endtask

  // Hold until every queued word is taken and every top has come back.
  task automatic wait_settled();
    while (words_accepted != words_queued || awaited_tops.size() != 0) @(negedge clk);
  endtask

  // Request driver: offer words from the pending queue, gap after each accepted word.
  always @(negedge clk) begin
    heap_word_t w;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (send_gap > 0) begin
        req_ch.valid <= 1'b0;
        send_gap--;
      end else if (pending_words.size() == 0) begin
        req_ch.valid <= 1'b0;
      end else begin
        w = pending_words.pop_front();
        req_ch.action        <= w.action;
        req_ch.item_priority <= w.prio;
        req_ch.item_data     <= w.data;
        req_ch.valid         <= 1'b1;
        send_gap = pick_gap();
      end
    end
  end

  // Response sink: random stalls, plus long holds on request.
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (holds_served < holds_asked) begin
        holds_served++;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Monitor: check returned tops, then predict for the word taken at this edge.
  always @(posedge clk) begin
    queue_top_t want;
    if (rst) begin
      req_taken = 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (awaited_tops.size() == 0) begin
          $error("unexpected result word: top_priority 0x%08h entry_total %0d",
                 rsp_ch.top_priority, rsp_ch.entry_total);
          err_count++;
        end else begin
          want = awaited_tops.pop_front();
          field_check("top_valid",    32'(want.top_valid),    32'(rsp_ch.top_valid));
          field_check("top_priority", want.top_priority,      rsp_ch.top_priority);
          field_check("top_data",     want.top_data,          rsp_ch.top_data);
          field_check("entry_total",  32'(want.entry_total),  32'(rsp_ch.entry_total));
          field_check("status",       32'(want.status),       32'(rsp_ch.status));
        end
      end
      req_taken = req_ch.valid && req_ch.ready;
      if (req_taken) begin
        heap_update(req_ch.action, req_ch.item_priority, req_ch.item_data);
        words_accepted++;
      end
    end
  end

  initial begin
    rst                  = 1'b1;
    req_ch.valid         = 1'b0;
    req_ch.action        = OP_PUSH;
    req_ch.item_priority = '0;
    req_ch.item_data     = '0;
    rsp_ch.ready         = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // pop on empty, extremes, equal priorities at root and below it, drain past empty
    queue_word(OP_POP,  32'sh7fff_ffff, 32'hffff_ffff);
    queue_word(OP_PUSH, 32'sd0,         32'h0000_0000);
    queue_word(OP_PUSH, 32'sh7fff_ffff, 32'hffff_ffff);
    queue_word(OP_PUSH, 32'sh8000_0000, 32'h0000_0001);
    queue_word(OP_PUSH, -32'sd1,        32'h0000_0002);
    queue_word(OP_PUSH, 32'sd7,         32'h0000_000a);
    queue_word(OP_PUSH, 32'sd7,         32'h0000_000b);
    queue_word(OP_PUSH, 32'sh8000_0000, 32'h5555_5555);
    queue_word(OP_PUSH, -32'sd1,        32'haaaa_aaaa);
    for (int i = 0; i < 9; i++) queue_word(OP_POP, 32'sd0, 32'h0000_0000);
    wait_settled();

    // fill past capacity, then drain past empty
    queue_random(150, 90, 30);
    queue_random(150, 10, 30);
    wait_settled();

    // stall the response side while words keep coming
    holds_asked++;
    queue_random(100, 60, 50);
    queue_random(400, 52, 70);
    wait_settled();

    calm = 1'b1;
    queue_random(300, 50, 20);
    wait_settled();
    calm = 1'b0;

    queue_random(200, 75, 60);
    queue_random(200, 25, 60);
    queue_random(350, 50, 40);
    wait_settled();
    repeat (30) @(negedge clk);

    if (err_count == 0 && awaited_tops.size() == 0) begin
      $display("[binary_min_heap_queue_core] OK");
    end else begin
      $display("[binary_min_heap_queue_core] ERROR");
    end
    $finish;
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("[binary_min_heap_queue_core] ERROR");
    $finish;
  end

endmodule

FILE: binary_min_heap_queue_core.f
rtl/core/hmq_pkg.sv
rtl/core/hmq_req_if.sv
rtl/core/hmq_rsp_if.sv
rtl/core/hmq_ctrl.sv
rtl/core/hmq_dpath.sv
rtl/core/binary_min_heap_queue_core.sv
dv/tb_binary_min_heap_queue_core.sv
